>>> design/lsbx_pkg.sv
// lsbx_pkg: shared types and constants for the LSB stego BMP extractor.
// Used by lsbx_decode and lsb_stego_bmp_extractor_top; depends on nothing.
package lsbx_pkg;

   // One byte of the image file
   typedef struct packed {
      logic [7:0] carrier_byte;
      logic       start_req;
   } req_type;

   // One decoded result
   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic        last;
   } rsp_type;

   // Configuration registers as seen by the decoder
   typedef struct packed {
      logic [9:0]  header_skip;
      logic [3:0]  magic_length;
      logic [63:0] magic_value;
   } cfg_type;

   // Result kinds
   localparam logic [2:0] KIND_EXT_SIZE = 3'd0;
   localparam logic [2:0] KIND_EXT_CHAR = 3'd1;
   localparam logic [2:0] KIND_FILE_SIZE = 3'd2;
   localparam logic [2:0] KIND_DATA = 3'd3;
   localparam logic [2:0] KIND_MISMATCH = 3'd4;

   // Register indexes (byte address = 8 * index)
   localparam logic [1:0] REG_HEADER_SKIP = 2'd0;
   localparam logic [1:0] REG_MAGIC_LENGTH = 2'd1;
   localparam logic [1:0] REG_MAGIC_VALUE = 2'd2;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 64;

   // Register reset values
   localparam logic [9:0]  HEADER_SKIP_RESET = 10'd54;
   localparam logic [3:0]  MAGIC_LENGTH_RESET = 4'd2;
   localparam logic [63:0] MAGIC_VALUE_RESET = 64'd0;

   // Carrier bits per hidden value, minus one
   localparam logic [4:0] CHAR_BITS_M1 = 5'd7;
   localparam logic [4:0] SIZE_BITS_M1 = 5'd31;

endpackage

>>> design/lsbx_decode.sv
// lsbx_decode: per-byte decode state machine plus the result register.
// Depends on lsbx_pkg.
module lsbx_decode #(
   parameter int MAX_MAGIC_BYTES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_accept,
   input  lsbx_pkg::req_type req_data,
   input  lsbx_pkg::cfg_type cfg,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output lsbx_pkg::rsp_type rsp_data
);
   import lsbx_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_MAGIC,
      PH_EXT_SIZE,
      PH_EXT_CHARS,
      PH_FILE_SIZE,
      PH_DATA,
      PH_DONE
   } phase_type;

   localparam logic [3:0] MAX_MAGIC = 4'(MAX_MAGIC_BYTES);

   phase_type   phase_ff, phase_in;
   logic [4:0]  bit_count_ff, bit_count_in;
   logic [31:0] shift_ff, shift_in;
   logic [9:0]  pos_ff, pos_in;
   logic [30:0] remain_ff, remain_in;
   logic        mismatch_ff, mismatch_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff;

   logic        emit;
   rsp_type     result;
   logic [3:0]  magic_eff;
   logic        used_up;
   logic        bit_in;
   logic [4:0]  need_m1;
   logic [31:0] word;
   logic        size_neg;
   logic [30:0] remain_dec;

   assign magic_eff = (cfg.magic_length > MAX_MAGIC) ? MAX_MAGIC : cfg.magic_length;
   assign bit_in = req_data.carrier_byte[0];

   always_comb begin
      phase_in = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in = shift_ff;
      pos_in = pos_ff;
      remain_in = remain_ff;
      mismatch_in = mismatch_ff;
      emit = 1'b0;
      result = '0;
      used_up = 1'b0;
      need_m1 = CHAR_BITS_M1;
      word = '0;
      size_neg = 1'b0;
      remain_dec = '0;

      if (req_data.start_req) begin
         phase_in = PH_HEADER;
         bit_count_in = '0;
         shift_in = '0;
         pos_in = '0;
         remain_in = '0;
         mismatch_in = 1'b0;
      end

      // Header skip
      if (phase_in == PH_HEADER) begin
         if (pos_in < cfg.header_skip) begin
            pos_in = pos_in + 10'd1;
            used_up = 1'b1;
         end else begin
            phase_in = PH_MAGIC;
            pos_in = '0;
            mismatch_in = 1'b0;
            bit_count_in = '0;
            shift_in = '0;
         end
      end

      // All magic chars already in (empty magic, or length lowered)
      if (!used_up && phase_in == PH_MAGIC && pos_in >= {6'd0, magic_eff}) begin
         bit_count_in = '0;
         shift_in = '0;
         if (mismatch_in) begin
            phase_in = PH_DONE;
            emit = 1'b1;
            result = '{kind: KIND_MISMATCH, value: 32'd0, last: 1'b1};
            used_up = 1'b1;
         end else begin
            phase_in = PH_EXT_SIZE;
            if (magic_eff != 4'd0) begin
               used_up = 1'b1;
            end
         end
      end

      if (!used_up && phase_in != PH_DONE) begin
         need_m1 = (phase_in == PH_EXT_SIZE || phase_in == PH_FILE_SIZE) ?
                   SIZE_BITS_M1 : CHAR_BITS_M1;
         word = {shift_in[30:0], bit_in};
         if (bit_count_in < need_m1) begin
            bit_count_in = bit_count_in + 5'd1;
            shift_in = word;
         end else begin
            bit_count_in = '0;
            shift_in = '0;
            size_neg = word[31];
            remain_dec = (remain_in != 31'd0) ? remain_in - 31'd1 : remain_in;
            case (phase_in)
               PH_MAGIC: begin
                  if (word[7:0] != cfg.magic_value[pos_in[2:0]*8 +: 8]) begin
                     mismatch_in = 1'b1;
                  end
                  pos_in = pos_in + 10'd1;
                  if (pos_in >= {6'd0, magic_eff}) begin
                     if (mismatch_in) begin
                        phase_in = PH_DONE;
                        emit = 1'b1;
                        result = '{kind: KIND_MISMATCH, value: 32'd0, last: 1'b1};
                     end else begin
                        phase_in = PH_EXT_SIZE;
                     end
                  end
               end
               PH_EXT_SIZE: begin
                  remain_in = size_neg ? 31'd0 : word[30:0];
                  phase_in = (remain_in != 31'd0) ? PH_EXT_CHARS : PH_FILE_SIZE;
                  emit = 1'b1;
                  result = '{kind: KIND_EXT_SIZE, value: word, last: 1'b0};
               end
               PH_EXT_CHARS: begin
                  remain_in = remain_dec;
                  if (remain_dec == 31'd0) begin
                     phase_in = PH_FILE_SIZE;
                  end
                  emit = 1'b1;
                  result = '{kind: KIND_EXT_CHAR, value: {24'd0, word[7:0]}, last: 1'b0};
               end
               PH_FILE_SIZE: begin
                  remain_in = size_neg ? 31'd0 : word[30:0];
                  phase_in = (remain_in != 31'd0) ? PH_DATA : PH_DONE;
                  emit = 1'b1;
                  result = '{kind: KIND_FILE_SIZE, value: word,
                             last: (remain_in == 31'd0)};
               end
               default: begin
                  remain_in = remain_dec;
                  if (remain_dec == 31'd0) begin
                     phase_in = PH_DONE;
                  end
                  emit = 1'b1;
                  result = '{kind: KIND_DATA, value: {24'd0, word[7:0]},
                             last: (remain_dec == 31'd0)};
               end
            endcase
         end
      end
   end

   // Result register frees up when taken; the top stalls input while it is held
   assign rsp_valid_in = req_accept ? emit : (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         bit_count_ff <= '0;
         shift_ff <= '0;
         pos_ff <= '0;
         remain_ff <= '0;
         mismatch_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            phase_ff <= phase_in;
            bit_count_ff <= bit_count_in;
            shift_ff <= shift_in;
            pos_ff <= pos_in;
            remain_ff <= remain_in;
            mismatch_ff <= mismatch_in;
         end
      end
      if (req_accept && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

>>> design/lsb_stego_bmp_extractor_top.sv
// LSB stego BMP extractor, top level: register port, input handshake, decoder.
// Results show the cycle after their byte; one byte per cycle while req_stall is low.
// The byte is decoded in one pass into the result register, which alone gates input.
// Synchronous active-high reset: registers to defaults (skip 54, magic length 2,
// magic 0), decoder to the header phase, no result pending.
// Depends on lsbx_pkg and lsbx_decode.
module lsb_stego_bmp_extractor_top #(
   parameter int MAX_MAGIC_BYTES = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input byte channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lsbx_pkg::req_type                   req_data,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lsbx_pkg::rsp_type                   rsp_data,
   // Register port, registers at byte addresses 0, 8, 16
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lsbx_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [lsbx_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [lsbx_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import lsbx_pkg::*;

   logic [9:0]  header_skip_ff;
   logic [3:0]  magic_length_ff;
   logic [63:0] magic_value_ff;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic        req_accept;
   cfg_type     cfg;

   // Zero-wait-state port
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite;
   assign csr_index = csr_paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         header_skip_ff <= HEADER_SKIP_RESET;
         magic_length_ff <= MAGIC_LENGTH_RESET;
         magic_value_ff <= MAGIC_VALUE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_HEADER_SKIP:  header_skip_ff <= csr_pwdata[9:0];
            REG_MAGIC_LENGTH: magic_length_ff <= csr_pwdata[3:0];
            REG_MAGIC_VALUE:  magic_value_ff <= csr_pwdata;
            default: ;  // unmapped address, write dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_HEADER_SKIP:  csr_prdata = {54'd0, header_skip_ff};
         REG_MAGIC_LENGTH: csr_prdata = {60'd0, magic_length_ff};
         REG_MAGIC_VALUE:  csr_prdata = magic_value_ff;
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg = '{header_skip: header_skip_ff, magic_length: magic_length_ff,
                  magic_value: magic_value_ff};

   // A new item can enter whenever the result register is empty or being
   // taken in this cycle; at most one result per item keeps this exact.
   assign req_stall = rsp_valid & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   lsbx_decode #(
      .MAX_MAGIC_BYTES(MAX_MAGIC_BYTES)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .req_accept(req_accept),
      .req_data  (req_data),
      .cfg       (cfg),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/lsbx_decode_check.sv
// lsbx_decode_check: watches the byte, result and register ports of the extractor,
// predicts every decoded result and compares it with what the block returns.
// Depends on lsbx_pkg for the item types, result kinds and register indexes.
module lsbx_decode_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  lsbx_pkg::req_type                   req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  lsbx_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic                                csr_pready,
   input  logic [lsbx_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [lsbx_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output int                                  fail_count,
   output int                                  decoded_waiting
);
   import lsbx_pkg::*;

   localparam int MAGIC_MAX = 8;

   typedef enum logic [2:0] {
      ST_HEADER, ST_MAGIC, ST_EXT_SIZE, ST_EXT_CHARS, ST_FILE_SIZE, ST_DATA, ST_DONE
   } stage_type;

   // decoder copy
   stage_type   stage;
   logic [4:0]  bits_in;
   logic [31:0] shifter;
   logic [31:0] position;
   logic [31:0] remaining;
   logic        magic_bad;

   // register copy
   logic [9:0]  skip_cfg;
   logic [3:0]  mlen_cfg;
   logic [63:0] magic_cfg;

   rsp_type decoded_q[$];
   int      errors;

   initial begin
      fail_count = 0;
      decoded_waiting = 0;
      errors = 0;
   end

   function automatic void clear_decoder();
      stage = ST_HEADER;
      bits_in = '0;
      shifter = '0;
      position = '0;
      remaining = '0;
      magic_bad = 1'b0;
   endfunction

   function automatic int magic_chars();
      return (mlen_cfg > MAGIC_MAX) ? MAGIC_MAX : int'(mlen_cfg);
   endfunction

   // all magic characters seen: flag the mismatch or move to the extension size
   function automatic bit close_magic(output rsp_type res);
      bits_in = '0;
      shifter = '0;
      res = '0;
      if (magic_bad) begin
         stage = ST_DONE;
         res.kind = KIND_MISMATCH;
         res.last = 1'b1;
         return 1'b1;
      end
      stage = ST_EXT_SIZE;
      return 1'b0;
   endfunction

   function automatic bit decode_byte(input req_type item, output rsp_type res);
      logic [31:0] word;
      logic [31:0] size_eff;
      int          need;
      res = '0;
      if (item.start_req) clear_decoder();
      if (stage == ST_HEADER) begin
         if (position < 32'(skip_cfg)) begin
            position++;
            return 1'b0;
         end
         stage = ST_MAGIC;
         position = '0;
         magic_bad = 1'b0;
         bits_in = '0;
         shifter = '0;
      end
      if (stage == ST_MAGIC && position >= 32'(magic_chars())) begin
         if (close_magic(res)) return 1'b1;
         // length lowered while magic was in flight: this byte only closes it
         if (magic_chars() != 0) return 1'b0;
      end
      if (stage == ST_DONE) return 1'b0;
      need = (stage == ST_EXT_SIZE || stage == ST_FILE_SIZE) ? 32 : 8;
      shifter = {shifter[30:0], item.carrier_byte[0]};
      if (int'(bits_in) + 1 < need) begin
         bits_in++;
         return 1'b0;
      end
      word = shifter;
      bits_in = '0;
      shifter = '0;
      case (stage)
         ST_MAGIC: begin
            if (position < 32'd8 && word[7:0] != 8'(magic_cfg >> (8 * position)))
               magic_bad = 1'b1;
            position++;
            if (position >= 32'(magic_chars())) return close_magic(res);
            return 1'b0;
         end
         ST_EXT_SIZE: begin
            size_eff = word[31] ? '0 : word;
            remaining = size_eff;
            stage = (size_eff != 0) ? ST_EXT_CHARS : ST_FILE_SIZE;
            res.kind = KIND_EXT_SIZE;
            res.value = word;
         end
         ST_EXT_CHARS: begin
            if (remaining != 0) remaining--;
            if (remaining == 0) stage = ST_FILE_SIZE;
            res.kind = KIND_EXT_CHAR;
            res.value = {24'd0, word[7:0]};
         end
         ST_FILE_SIZE: begin
            size_eff = word[31] ? '0 : word;
            remaining = size_eff;
            stage = (size_eff != 0) ? ST_DATA : ST_DONE;
            res.kind = KIND_FILE_SIZE;
            res.value = word;
            res.last = (size_eff == 0);
         end
         default: begin
            if (remaining != 0) remaining--;
            if (remaining == 0) stage = ST_DONE;
            res.kind = KIND_DATA;
            res.value = {24'd0, word[7:0]};
            res.last = (remaining == 0);
         end
      endcase
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (errors < 200)
         $display("%0t: %s mismatch, got %0h, want %0h", $time, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type made;
      if (reset) begin
         skip_cfg = HEADER_SKIP_RESET;
         mlen_cfg = MAGIC_LENGTH_RESET;
         magic_cfg = MAGIC_VALUE_RESET;
         clear_decoder();
         decoded_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               report_mismatch("unrequested result", rsp_data.value, '0);
            end else begin
               want = decoded_q.pop_front();
               if (rsp_data.kind != want.kind)
                  report_mismatch("kind", 32'(rsp_data.kind), 32'(want.kind));
               if (rsp_data.value != want.value)
                  report_mismatch("value", rsp_data.value, want.value);
               if (rsp_data.last != want.last)
                  report_mismatch("last", 32'(rsp_data.last), 32'(want.last));
            end
         end
         if (req_valid && !req_stall) begin
            if (decode_byte(req_data, made)) decoded_q.push_back(made);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_WIDTH-1 -: 2])
               REG_HEADER_SKIP: skip_cfg = csr_pwdata[9:0];
               REG_MAGIC_LENGTH: mlen_cfg = csr_pwdata[3:0];
               REG_MAGIC_VALUE: magic_cfg = csr_pwdata;
               default: ;
            endcase
         end
      end
      decoded_waiting <= decoded_q.size();
      fail_count <= errors;
   end

endmodule

>>> tb/lsb_stego_bmp_extractor_top_tb.sv
// Testbench top for the LSB stego BMP extractor: builds BMP-like byte streams with
// hidden fields, drives them through the block and gives the verdict.
// Depends on lsbx_pkg, lsb_stego_bmp_extractor_top and lsbx_decode_check.
module lsb_stego_bmp_extractor_top_tb;
   import lsbx_pkg::*;

   localparam int         HOLD_CYCLES = 200;   // long receiver hold-off
   localparam int         QUIET_LIMIT = 2000;  // cycles with no handshake at all
   localparam int         PHASE_ITEMS = 120;   // random items per idling phase
   localparam logic [1:0] REG_BEYOND = 2'd3;   // first index past the register list

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_type                   rsp_data;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   int errors_seen;
   int decoded_waiting;

   // idling odds in percent, changed per phase
   int send_idle_pct = 13;
   int recv_idle_pct = 83;

   // receiver hold-off requests: main process asks, receiver process grants
   int holds_asked = 0;
   int holds_given = 0;

   // register values as last written, used to build matching files
   logic [9:0]  cur_skip;
   logic [3:0]  cur_mlen;
   logic [63:0] cur_magic;

   logic [7:0] file_bytes[$];   // bytes of the file being built
   int         item_total = 0;  // bytes accepted so far
   int         quiet_cycles;

   lsb_stego_bmp_extractor_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   lsbx_decode_check decode_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .fail_count     (errors_seen),
      .decoded_waiting(decoded_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result side: random stall each cycle, plus a long hold-off on request.
   // The hold is counted here so the sender keeps pushing bytes meanwhile and
   // the single result register backs up into req_stall.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_asked != holds_given) begin
            holds_given++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog: ends the run if no item, result or register write moves for too long.
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // One byte on the input channel; returns right after the accepting edge
   // without touching req_valid, so the next call can keep it high.
   task automatic send_byte(input logic [7:0] b, input logic start);
      req_type item;
      item.carrier_byte = b;
      item.start_req = start;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Send the first cut bytes of the built file. Later bytes carry a start
   // with the given odds, to break files apart.
   task automatic send_queue(input logic first_start, input int cut, input int start_pct);
      int   i;
      logic start;
      for (i = 0; i < cut && i < file_bytes.size(); i++) begin
         start = (i == 0) ? first_start : ($urandom_range(99) < start_pct);
         send_byte(file_bytes[i], start);
         item_total++;
      end
      file_bytes.delete();
   endtask

   // Hide a value MSB first in the LSBs of nbits carriers; upper bits are noise.
   task automatic push_value(input logic [31:0] v, input int nbits);
      int b;
      for (b = nbits - 1; b >= 0; b--)
         file_bytes.push_back({7'($urandom), v[b]});
   endtask

   task automatic push_noise(input int n);
      int i;
      for (i = 0; i < n; i++) file_bytes.push_back(8'($urandom));
   endtask

   // Whole file for the current registers. Sizes with bit 31 set count as zero,
   // so no characters or data follow them. bad_char >= 0 corrupts that magic char.
   task automatic compose_file(input logic [31:0] ext_size, input logic [31:0] file_size,
                               input int bad_char);
      int         i;
      int         n_magic;
      logic [7:0] ch;
      n_magic = (cur_mlen > 8) ? 8 : int'(cur_mlen);
      push_noise(int'(cur_skip));
      for (i = 0; i < n_magic; i++) begin
         ch = cur_magic[8*i +: 8];
         if (i == bad_char) ch = ch ^ 8'($urandom_range(1, 255));
         push_value({24'd0, ch}, 8);
      end
      push_value(ext_size, 32);
      if (!ext_size[31])
         for (i = 0; i < int'(ext_size); i++) push_value(32'($urandom_range(0, 255)), 8);
      push_value(file_size, 32);
      if (!file_size[31])
         for (i = 0; i < int'(file_size); i++) push_value(32'($urandom_range(0, 255)), 8);
   endtask

   // Let every predicted result come back, then keep idling for bytes
   // that produce nothing but may still be in flight.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoded_waiting != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Setup phase, access phase, then an idle phase so back-to-back writes
   // never assign psel twice in one step.
   task automatic csr_write(input logic [1:0] index, input logic [63:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 3'b000};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Unused upper data bits get noise; the block keeps only the field width.
   task automatic set_config(input logic [9:0] skip, input logic [3:0] mlen,
                             input logic [63:0] magic);
      drain();
      csr_write(REG_HEADER_SKIP, {$urandom, 22'($urandom), skip});
      csr_write(REG_MAGIC_LENGTH, {$urandom, 28'($urandom), mlen});
      csr_write(REG_MAGIC_VALUE, magic);
      cur_skip = skip;
      cur_mlen = mlen;
      cur_magic = magic;
   endtask

   task automatic random_config();
      logic [9:0] skip;
      logic [3:0] mlen;
      skip = ($urandom_range(99) < 70) ? 10'($urandom_range(0, 6))
                                       : 10'($urandom_range(7, 64));
      mlen = ($urandom_range(99) < 75) ? 4'($urandom_range(0, 3))
                                       : 4'($urandom_range(4, 15));
      set_config(skip, mlen, {$urandom, $urandom});
   endtask

   // Mostly well-formed files with random content; some cut short, some with
   // a bad magic or negative sizes; the rest is raw noise with stray starts.
   task automatic random_file();
      logic [31:0] ext_size;
      logic [31:0] file_size;
      int          bad;
      int          n_magic;
      int          cut;
      if ($urandom_range(99) < 20) begin
         push_noise($urandom_range(1, 40));
         send_queue(1'($urandom_range(1)), file_bytes.size(), 10);
      end else begin
         n_magic = (cur_mlen > 8) ? 8 : int'(cur_mlen);
         ext_size = ($urandom_range(99) < 8) ? {1'b1, 31'($urandom)}
                                             : 32'($urandom_range(0, 4));
         file_size = ($urandom_range(99) < 8) ? {1'b1, 31'($urandom)}
                                              : 32'($urandom_range(0, 24));
         bad = -1;
         if (n_magic > 0 && $urandom_range(99) < 15) bad = $urandom_range(0, n_magic - 1);
         compose_file(ext_size, file_size, bad);
         push_noise($urandom_range(0, 3));
         cut = file_bytes.size();
         if ($urandom_range(99) < 10) cut = $urandom_range(1, cut);
         send_queue(1'b1, cut, 0);
      end
   endtask

   task automatic run_phase(input int count);
      int stop_at;
      stop_at = item_total + count;
      while (item_total < stop_at) begin
         if ($urandom_range(99) < 25) random_config();
         random_file();
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      cur_skip = HEADER_SKIP_RESET;
      cur_mlen = MAGIC_LENGTH_RESET;
      cur_magic = MAGIC_VALUE_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part: sender idles a little, receiver a lot ----

      // Reset registers, and no start on the first byte after reset.
      // Trailing bytes after the last result must be ignored.
      compose_file(32'd1, 32'd1, -1);
      push_noise(2);
      send_queue(1'b0, file_bytes.size(), 0);

      // No header, no magic. Empty extension, then a negative file size that
      // counts as an empty file.
      set_config(10'd0, 4'd0, '1);
      compose_file(32'd0, 32'hFFFF_FFFF, -1);
      send_queue(1'b1, file_bytes.size(), 0);

      // Negative extension size counts as zero; file size zero ends the file.
      compose_file(32'h8000_0001, 32'd0, -1);
      send_queue(1'b1, file_bytes.size(), 0);

      // Magic length above the maximum acts as the maximum.
      set_config(10'd1, 4'd15, {$urandom, $urandom});
      compose_file(32'd2, 32'd3, -1);
      send_queue(1'b1, file_bytes.size(), 0);

      // Mismatch on the last magic char, then bytes ignored until a start.
      set_config(10'd3, 4'd3, '0);
      compose_file(32'd1, 32'd1, 2);
      push_noise(3);
      send_queue(1'b1, file_bytes.size(), 0);

      // Magic length lowered with two of four chars in: the next byte only
      // performs the check and carries no bit.
      set_config(10'd0, 4'd4, {$urandom, $urandom});
      push_value({24'd0, cur_magic[7:0]}, 8);
      push_value({24'd0, cur_magic[15:8]}, 8);
      send_queue(1'b1, file_bytes.size(), 0);
      drain();
      csr_write(REG_MAGIC_LENGTH, 64'd1);
      cur_mlen = 4'd1;
      push_noise(1);
      push_value(32'd0, 32);
      push_value(32'd1, 32);
      push_value(32'h0000_00FF, 8);
      send_queue(1'b0, file_bytes.size(), 0);

      // Write past the register list: no effect. Then a file with a huge
      // extension size, cut off by a new start.
      drain();
      csr_write(REG_BEYOND, {$urandom, $urandom});
      push_value({24'd0, cur_magic[7:0]}, 8);
      push_value(32'h7FFF_FFFF, 32);
      push_value(32'd0, 8);
      push_value(32'hFF, 8);
      send_queue(1'b1, file_bytes.size(), 0);
      compose_file(32'd0, 32'd1, -1);
      send_queue(1'b1, file_bytes.size(), 0);

      // All-ones magic at full length
      set_config(10'd0, 4'd8, '1);
      compose_file(32'd0, 32'd0, -1);
      compose_file(32'd0, 32'd2, -1);
      send_queue(1'b1, file_bytes.size(), 0);

      // ---- random part, three idling phases ----
      run_phase(PHASE_ITEMS);

      send_idle_pct = 83;
      recv_idle_pct = 13;
      run_phase(PHASE_ITEMS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // Long hold-off on the result side while a data-heavy file streams in
      set_config(10'd2, 4'd1, {$urandom, $urandom});
      holds_asked++;
      compose_file(32'd0, 32'd24, -1);
      send_queue(1'b1, file_bytes.size(), 0);
      run_phase(PHASE_ITEMS);

      drain();
      if (errors_seen == 0 && decoded_waiting == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
